// File: rtl/tci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tci_pkg: thruster curve interpolator shared definitions
// Widths, the force curve ROM contents and ROM access helpers.
// ----------------------------------------------------------------------------
package tci_pkg;

  localparam int CurvePoints  = 201;
  localparam int CurveLen     = 201;
  localparam int FractionBits = 16;
  localparam int ValueBits    = 23;

  localparam int IdxBits  = $clog2(CurvePoints);
  localparam int DiffBits = ValueBits + 1;
  localparam int MaBits   = ((DiffBits > FractionBits + 2) ? DiffBits : FractionBits + 2) + 1;
  localparam int MbBits   = (IdxBits > FractionBits + 1) ? IdxBits : FractionBits + 1;
  localparam int ProdBits = MaBits + MbBits + 1;
  localparam int WideBits = ((ValueBits > FractionBits + 2) ? ValueBits : FractionBits + 2) + 2;
  localparam int QuoBits  = FractionBits + 2;
  localparam int DenBits  = DiffBits + IdxBits + 1;
  localparam int NumBits  = IdxBits + DiffBits + FractionBits + 3;

  localparam longint unsigned DecimalScale = 64'd10000000000;
  localparam longint ValueMax = (64'sd1 <<< (ValueBits - 1)) - 64'sd1;
  localparam longint ValueMin = -(64'sd1 <<< (ValueBits - 1));

  typedef logic signed [ValueBits-1:0] curve_rom_t [CurvePoints];

  // curve forces in units of 1e-10 N, one per 0.01 command step
  localparam longint CurveForceE10 [CurveLen] = '{
    -64'sd399079290400, -64'sd397225866200, -64'sd394556935400, -64'sd388774252000,
    -64'sd382546746900, -64'sd379432994300, -64'sd374984776300, -64'sd372760667300,
    -64'sd367867627500, -64'sd364309053100, -64'sd358526369700, -64'sd351854042800,
    -64'sd345181715800, -64'sd338509388800, -64'sd333171527200, -64'sd324719913000,
    -64'sd318937229700, -64'sd314044189900, -64'sd304702932100, -64'sd298030605100,
    -64'sd293582387100, -64'sd288244525500, -64'sd280682555000, -64'sd276679158800,
    -64'sd271786119000, -64'sd265558613800, -64'sd260665574000, -64'sd253103603400,
    -64'sd249989850900, -64'sd245986454700, -64'sd240648593100, -64'sd233531444300,
    -64'sd230862513500, -64'sd223300542900, -64'sd219297146700, -64'sd215293750600,
    -64'sd207731780000, -64'sd204173205600, -64'sd198390522200, -64'sd193942304200,
    -64'sd190383729800, -64'sd182376937500, -64'sd177928719500, -64'sd173035679700,
    -64'sd166808174500, -64'sd163694421900, -64'sd157911738500, -64'sd152573876900,
    -64'sd148570480800, -64'sd145901550000, -64'sd141008510200, -64'sd137005114000,
    -64'sd132112074200, -64'sd127663856200, -64'sd123215638200, -64'sd117877776700,
    -64'sd113874380500, -64'sd109870984300, -64'sd108091697100, -64'sd103198657300,
    -64'sd100084904700, -64'sd96081508510, -64'sd92522934130, -64'sd88519537940,
    -64'sd85405785350, -64'sd80512745560, -64'sd76954171170, -64'sd72950774980,
    -64'sd70281844190, -64'sd66723269800, -64'sd63609517210, -64'sd60495764620,
    -64'sd56937190230, -64'sd52933794040, -64'sd50264863250, -64'sd47151110660,
    -64'sd43592536270, -64'sd40923605480, -64'sd37809852890, -64'sd34696100300,
    -64'sd31582347710, -64'sd28913416910, -64'sd25354842520, -64'sd23130733530,
    -64'sd20461802740, -64'sd17792871950, -64'sd14679119360, -64'sd12455010360,
    -64'sd10230901370, -64'sd8451614175, -64'sd6672326980, -64'sd4893039785,
    -64'sd3558574389,
    64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0,
    64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0,
    64'sd4003396188, 64'sd5337861584, 64'sd7561970578, 64'sd9786079571,
    64'sd12455010360, 64'sd15123941160, 64'sd17792871950, 64'sd21351446340,
    64'sd24465198930, 64'sd28468595120, 64'sd31582347710, 64'sd35140922100,
    64'sd39144318280, 64'sd42702892670, 64'sd46261467060, 64'sd50264863250,
    64'sd54713081240, 64'sd59161299220, 64'sd62719873610, 64'sd66723269800,
    64'sd70726665990, 64'sd76064527570, 64'sd80067923760, 64'sd85405785350,
    64'sd88964359740, 64'sd92967755920, 64'sd97415973910, 64'sd101419370100,
    64'sd107646875300, 64'sd112095093300, 64'sd116098489500, 64'sd121436351000,
    64'sd125439747200, 64'sd130332787000, 64'sd136115470400, 64'sd141008510200,
    64'sd145456728200, 64'sd150794589800, 64'sd155687629500, 64'sd161915134700,
    64'sd165918530900, 64'sd172590857900, 64'sd178818363100, 64'sd184156224700,
    64'sd189494086200, 64'sd195276769600, 64'sd200614631200, 64'sd208176601800,
    64'sd213514463400, 64'sd217517859600, 64'sd223300542900, 64'sd233531444300,
    64'sd238424484100, 64'sd246876098300, 64'sd252658781700, 64'sd260220752200,
    64'sd267782722800, 64'sd270451653600, 64'sd278458446000, 64'sd283351485800,
    64'sd291803099900, 64'sd299365070500, 64'sd304702932100, 64'sd310930437300,
    64'sd315378655300, 64'sd323830269400, 64'sd330947418200, 64'sd335395636200,
    64'sd344292072200, 64'sd353633330000, 64'sd361195300500, 64'sd366533162100,
    64'sd374539954500, 64'sd381212281500, 64'sd387884608400, 64'sd398115509800,
    64'sd406567124000, 64'sd417242847200, 64'sd422135886900, 64'sd429697857500,
    64'sd442152867900, 64'sd443932155100, 64'sd455942343600, 64'sd461725027000,
    64'sd469286997600, 64'sd474180037400, 64'sd483521295200, 64'sd491528087500,
    64'sd497755592700, 64'sd504427919700, 64'sd507541672300, 64'sd511989890300,
    64'sd514362273200, 64'sd514362273200, 64'sd514362273200
  };

  // round to nearest, ties away from zero, then saturate
  function automatic logic signed [ValueBits-1:0] decimal_to_fixed(input longint v);
    longint unsigned mag;
    longint unsigned q;
    longint s;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = (mag * (64'd1 << FractionBits) + DecimalScale / 2) / DecimalScale;
    s = (v < 0) ? -longint'(q) : longint'(q);
    if (s > ValueMax) s = ValueMax;
    if (s < ValueMin) s = ValueMin;
    return ValueBits'(s);
  endfunction

  function automatic curve_rom_t build_rom();
    curve_rom_t rom;
    for (int i = 0; i < CurvePoints; i++) begin
      rom[i] = decimal_to_fixed(CurveForceE10[(i < CurveLen) ? i : CurveLen - 1]);
    end
    return rom;
  endfunction

  localparam curve_rom_t ForceRom = build_rom();

  function automatic logic signed [ValueBits-1:0] rom_at(input logic [IdxBits-1:0] idx);
    return ForceRom[idx];
  endfunction

endpackage
`default_nettype wire

// File: rtl/tci_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tci_in_if: request channel
// Carries the direction selector and the Q7.16 operand of one item.
// ----------------------------------------------------------------------------
interface tci_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [tci_pkg::ValueBits-1:0] operand_value;

  modport source (output valid, output action, output operand_value, input ready);
  modport sink (input valid, input action, input operand_value, output ready);
endinterface
`default_nettype wire

// File: rtl/tci_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tci_out_if: result channel
// Carries one Q7.16 result per item.
// ----------------------------------------------------------------------------
interface tci_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tci_pkg::ValueBits-1:0] result_value;

  modport source (output valid, output result_value, input ready);
  modport sink (input valid, input result_value, output ready);
endinterface
`default_nettype wire

// File: rtl/tci_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tci_divider: restoring radix-2 divider
// One quotient bit per cycle; the quotient is known to fit in QuoBits.
// ----------------------------------------------------------------------------
module tci_divider (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [tci_pkg::NumBits-1:0]     dividend_i,
  input  wire logic [tci_pkg::DenBits-1:0]     divisor_i,
  output logic                                 done_o,
  output logic      [tci_pkg::QuoBits-1:0]     quotient_o
);

  localparam int CntBits = $clog2(tci_pkg::QuoBits);

  logic                            busy_q;
  logic                            done_q;
  logic [CntBits-1:0]              cnt_q;
  logic [tci_pkg::NumBits-1:0]     rem_q;
  logic [tci_pkg::NumBits-1:0]     sdiv_q;
  logic [tci_pkg::QuoBits-1:0]     quo_q;
  logic                            fits;

  assign fits = (rem_q >= sdiv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(tci_pkg::QuoBits - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      sdiv_q <= tci_pkg::NumBits'(divisor_i) << (tci_pkg::QuoBits - 1);
      quo_q  <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - sdiv_q;
      end
      sdiv_q <= sdiv_q >> 1;
      quo_q  <= {quo_q[tci_pkg::QuoBits-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// File: rtl/thruster_curve_interpolator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thruster_curve_interpolator_unit: force <-> command through a ROM curve
// Binary search over the curve ROM, one shared multiplier and a serial
// divider under a small sequencer.
// ----------------------------------------------------------------------------
// latency force to command: binary ROM search, multiply, serial divide
// command to force: split, lookup, multiply, round; end points and a zero force
//   go straight to the result; one item at a time, the next accepted once the
//   result is in the output register
// reset: sequencer idle, output register empty; the curve ROM is constant
// ----------------------------------------------------------------------------
module thruster_curve_interpolator_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  tci_in_if.sink   item_i,
  tci_out_if.source result_o
);

  localparam int VB = tci_pkg::ValueBits;
  localparam int FB = tci_pkg::FractionBits;
  localparam int KBits = tci_pkg::ProdBits - FB - 1;

  localparam logic signed [tci_pkg::WideBits-1:0] OneW =
    tci_pkg::WideBits'(1) <<< FB;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_FETCH  = 4'd2;
  localparam logic [3:0] S_MULA   = 4'd3;
  localparam logic [3:0] S_MULB   = 4'd4;
  localparam logic [3:0] S_DIVGO  = 4'd5;
  localparam logic [3:0] S_DIVW   = 4'd6;
  localparam logic [3:0] S_CSPLIT = 4'd7;
  localparam logic [3:0] S_CLOOK  = 4'd8;
  localparam logic [3:0] S_CMUL   = 4'd9;
  localparam logic [3:0] S_CROUND = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state_q;
  logic       out_valid_q;

  logic signed [VB-1:0]                      x_q, res_q, f0_q, out_res_q;
  logic        [tci_pkg::IdxBits-1:0]        idx_q, hi_q;
  logic signed [tci_pkg::DiffBits-1:0]       d_q, xo_q;
  logic        [FB:0]                        r_q;
  logic signed [tci_pkg::ProdBits-1:0]       prod_q, prod_d;
  logic        [tci_pkg::NumBits-1:0]        num_q;

  logic                                      in_acc;
  logic                                      out_free;
  logic signed [VB-1:0]                      x_in;
  logic signed [tci_pkg::WideBits-1:0]       x_wide;
  logic        [tci_pkg::IdxBits:0]          mid_sum;
  logic        [tci_pkg::IdxBits-1:0]        mid;
  logic signed [tci_pkg::MaBits-1:0]         ma;
  logic        [tci_pkg::MbBits-1:0]         mb;
  logic signed [VB-1:0]                      rom_prev, rom_cur, rom_next;
  logic        [KBits-1:0]                   k_full;
  logic        [tci_pkg::ProdBits:0]         round_mag, round_q;
  logic signed [tci_pkg::ProdBits+1:0]       round_res;
  logic                                      div_start, div_done;
  logic        [tci_pkg::NumBits-1:0]        div_dividend;
  logic        [tci_pkg::DenBits-1:0]        div_divisor;
  logic        [tci_pkg::QuoBits-1:0]        div_quo;

  assign in_acc   = item_i.valid && item_i.ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign x_in     = item_i.operand_value;
  assign x_wide   = tci_pkg::WideBits'(x_in);

  assign item_i.ready       = (state_q == S_IDLE);
  assign result_o.valid     = out_valid_q;
  assign result_o.result_value = out_res_q;

  // search midpoint and ROM taps
  assign mid_sum  = {1'b0, idx_q} + {1'b0, hi_q};
  assign mid      = mid_sum[tci_pkg::IdxBits:1];
  assign rom_prev = tci_pkg::rom_at(idx_q - tci_pkg::IdxBits'(1));
  assign rom_cur  = tci_pkg::rom_at(idx_q);
  assign rom_next = tci_pkg::rom_at(idx_q + tci_pkg::IdxBits'(1));
  assign k_full   = prod_q[tci_pkg::ProdBits-1:FB+1];

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_IDLE: begin
        ma = tci_pkg::MaBits'(x_wide + OneW);
        mb = tci_pkg::MbBits'(tci_pkg::CurvePoints - 1);
      end
      S_MULA: begin
        ma = tci_pkg::MaBits'(d_q);
        mb = tci_pkg::MbBits'(idx_q - tci_pkg::IdxBits'(1));
      end
      S_CMUL: begin
        ma = tci_pkg::MaBits'(d_q);
        mb = tci_pkg::MbBits'(r_q);
      end
      default: begin
        ma = tci_pkg::MaBits'(d_q);
        mb = tci_pkg::MbBits'(tci_pkg::CurvePoints - 1);
      end
    endcase
    prod_d = tci_pkg::ProdBits'(ma) * tci_pkg::ProdBits'($signed({1'b0, mb}));
  end

  // round half away from zero after the fraction shift
  always_comb begin
    round_mag = prod_q[tci_pkg::ProdBits-1] ?
                (tci_pkg::ProdBits+1)'(-prod_q) : (tci_pkg::ProdBits+1)'(prod_q);
    round_q   = (round_mag + ((tci_pkg::ProdBits+1)'(1) << FB)) >> (FB + 1);
    if (prod_q[tci_pkg::ProdBits-1]) begin
      round_res = (tci_pkg::ProdBits+2)'(f0_q) - $signed({1'b0, round_q});
    end else begin
      round_res = (tci_pkg::ProdBits+2)'(f0_q) + $signed({1'b0, round_q});
    end
  end

  assign div_start    = (state_q == S_DIVGO);
  assign div_dividend = (num_q << 1) + tci_pkg::NumBits'(prod_q);
  assign div_divisor  = tci_pkg::DenBits'(prod_q) << 1;

  tci_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!item_i.action) begin
              if (x_in == '0 || x_in <= tci_pkg::rom_at('0) ||
                  x_in >= tci_pkg::rom_at(tci_pkg::IdxBits'(tci_pkg::CurvePoints - 1))) begin
                state_q <= S_FIN;
              end else begin
                state_q <= S_SEARCH;
              end
            end else if (x_wide <= -OneW || x_wide >= OneW) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_CSPLIT;
            end
          end
        end
        S_SEARCH: if (idx_q == hi_q) state_q <= S_FETCH;
        S_FETCH:  state_q <= S_MULA;
        S_MULA:   state_q <= S_MULB;
        S_MULB:   state_q <= S_DIVGO;
        S_DIVGO:  state_q <= S_DIVW;
        S_DIVW:   if (div_done) state_q <= S_FIN;
        S_CSPLIT: begin
          if (k_full >= KBits'(tci_pkg::CurvePoints - 1)) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_CLOOK;
          end
        end
        S_CLOOK:  state_q <= S_CMUL;
        S_CMUL:   state_q <= S_CROUND;
        S_CROUND: state_q <= S_FIN;
        S_FIN:    if (out_free) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == S_FIN && out_free) begin
      out_res_q <= res_q;
    end
    case (state_q)
      S_IDLE: begin
        x_q   <= x_in;
        idx_q <= tci_pkg::IdxBits'(1);
        hi_q  <= tci_pkg::IdxBits'(tci_pkg::CurvePoints - 1);
        if (!item_i.action) begin
          if (x_in == '0) begin
            res_q <= '0;
          end else if (x_in <= tci_pkg::rom_at('0)) begin
            res_q <= VB'(-OneW);
          end else begin
            res_q <= VB'(OneW);
          end
        end else if (x_wide <= -OneW) begin
          res_q <= tci_pkg::rom_at('0);
        end else begin
          res_q <= tci_pkg::rom_at(tci_pkg::IdxBits'(tci_pkg::CurvePoints - 1));
        end
      end
      S_SEARCH: begin
        // lower bound: first entry whose force is at least the operand
        if (idx_q != hi_q) begin
          if (tci_pkg::rom_at(mid) >= x_q) begin
            hi_q <= mid;
          end else begin
            idx_q <= mid + tci_pkg::IdxBits'(1);
          end
        end
      end
      S_FETCH: begin
        d_q  <= tci_pkg::DiffBits'(rom_cur) - tci_pkg::DiffBits'(rom_prev);
        xo_q <= tci_pkg::DiffBits'(x_q) - tci_pkg::DiffBits'(rom_prev);
      end
      S_MULB: begin
        num_q <= (tci_pkg::NumBits'(prod_q) + tci_pkg::NumBits'(xo_q)) << (FB + 1);
      end
      S_DIVW: begin
        res_q <= VB'(tci_pkg::WideBits'(div_quo) - OneW);
      end
      S_CSPLIT: begin
        idx_q <= tci_pkg::IdxBits'(k_full);
        r_q   <= prod_q[FB:0];
        res_q <= tci_pkg::rom_at(tci_pkg::IdxBits'(tci_pkg::CurvePoints - 1));
      end
      S_CLOOK: begin
        f0_q <= rom_cur;
        d_q  <= tci_pkg::DiffBits'(rom_next) - tci_pkg::DiffBits'(rom_cur);
      end
      S_CROUND: begin
        res_q <= VB'(round_res);
      end
      default: begin
      end
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !item_i.ready)
    else $error("item accepted while a previous item is in flight");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (idx_q <= hi_q))
    else $error("curve search bounds crossed");

  a_quotient_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVW && div_done) |->
      (div_quo <= (tci_pkg::QuoBits'(1) << (FB + 1))))
    else $error("interpolation fraction out of range");

endmodule
`default_nettype wire
